[rtl/alu32f_pkg.sv]
// alu32f_pkg: opcodes, decoded item type and flag type for the flag alu
// no dependencies
`timescale 1ns / 1ps
package alu32f_pkg;
	localparam int unsigned DataW = 32;
	localparam int unsigned OpW = 5;
	localparam int unsigned QueueDepth = 2;

	typedef enum logic [OpW-1:0] {
		OP_ADCS = 5'd0, OP_ADD = 5'd1, OP_ADDS = 5'd2, OP_ANDS = 5'd3, OP_ASRS = 5'd4,
		OP_BICS = 5'd5, OP_CMN = 5'd6, OP_CMP = 5'd7, OP_EORS = 5'd8, OP_LSLS = 5'd9,
		OP_LSRS = 5'd10, OP_MOV = 5'd11, OP_MOVS = 5'd12, OP_MULS = 5'd13,
		OP_MVNS = 5'd14, OP_NOP = 5'd15, OP_ORRS = 5'd16, OP_REV = 5'd17,
		OP_REV16 = 5'd18, OP_REVSH = 5'd19, OP_RORS = 5'd20, OP_RSBS = 5'd21,
		OP_SBCS = 5'd22, OP_SUB = 5'd23, OP_SUBS = 5'd24, OP_TST = 5'd25
	} opcode_t;

	typedef struct packed {
		logic n;
		logic z;
		logic c;
		logic v;
	} flags_t;

	// classified item handed from front to back
	typedef struct packed {
		logic [OpW-1:0] op;
		logic [DataW-1:0] a;
		logic [DataW-1:0] b;
		logic wr;
	} dec_t;
endpackage

[rtl/alu32f_if.sv]
// alu32f_if: valid/ready channel with a parameterized payload
// no dependencies
`timescale 1ns / 1ps
interface alu32f_if #(parameter type payload_t = logic) ();
	logic valid;
	logic ready;
	payload_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

[rtl/alu32_with_condition_flags_unit.sv]
// alu32_with_condition_flags_unit: 32-bit alu with nzcv flags, front queue and back
// depends on alu32f_pkg, alu32f_if, alu32f_front, alu32f_back
// path: an accepted input word is written into a queue entry, then executed into the output register
// throughput: one word per cycle while the output is taken, set by the single execute stage and its flag loop
// the two-entry queue between front and back lets either side stall alone
// reset: queue empty, output invalid, held nzcv flags zero
`timescale 1ns / 1ps
module alu32_with_condition_flags_unit (
	input logic clk,
	input logic arst_n,
	alu32f_if.sink in_ch,
	alu32f_if.source out_ch
);
	import alu32f_pkg::*;
	// input payload: {opcode, operand_a, operand_b}
	// output payload: {result, writes_result, n, z, c, v}
	logic q_valid, q_ready;
	dec_t q_item;

	// front: classify and queue
	alu32f_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_ch.valid), .in_ready(in_ch.ready),
		.opcode(in_ch.payload.opcode),
		.operand_a(in_ch.payload.operand_a),
		.operand_b(in_ch.payload.operand_b),
		.q_valid(q_valid), .q_ready(q_ready), .q_item(q_item)
	);

	// back: execute, keep flags, output register
	alu32f_back u_back (
		.clk(clk), .arst_n(arst_n),
		.q_valid(q_valid), .q_ready(q_ready), .q_item(q_item),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready),
		.result(out_ch.payload.result),
		.writes_result(out_ch.payload.writes_result),
		.flag_negative(out_ch.payload.flag_negative),
		.flag_zero(out_ch.payload.flag_zero),
		.flag_carry(out_ch.payload.flag_carry),
		.flag_overflow(out_ch.payload.flag_overflow)
	);
endmodule

[rtl/alu32f_front.sv]
// alu32f_front: accepts words, classifies write enable, two-entry queue
// depends on alu32f_pkg
`timescale 1ns / 1ps
module alu32f_front (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic [alu32f_pkg::OpW-1:0] opcode,
	input logic [alu32f_pkg::DataW-1:0] operand_a,
	input logic [alu32f_pkg::DataW-1:0] operand_b,
	output logic q_valid,
	input logic q_ready,
	output alu32f_pkg::dec_t q_item
);
	import alu32f_pkg::*;
	dec_t mem_q [QueueDepth];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;
	logic wr_en, push, pop;

	always_comb begin
		case (opcode)
			OP_CMP, OP_CMN, OP_TST, OP_NOP: wr_en = 1'b0;
			default: wr_en = (opcode <= OP_TST);
		endcase
	end

	assign in_ready = (cnt_q != 2'd2);
	assign push = in_valid && in_ready;
	assign q_valid = (cnt_q != 2'd0);
	assign pop = q_valid && q_ready;
	assign q_item = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= '{op: opcode, a: operand_a, b: operand_b, wr: wr_en};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end
endmodule

[rtl/alu32f_back.sv]
// alu32f_back: executes one word per cycle unless the output stalls,
// holds nzcv, registered output; depends on alu32f_pkg
`timescale 1ns / 1ps
module alu32f_back (
	input logic clk,
	input logic arst_n,
	input logic q_valid,
	output logic q_ready,
	input alu32f_pkg::dec_t q_item,
	output logic out_valid,
	input logic out_ready,
	output logic [alu32f_pkg::DataW-1:0] result,
	output logic writes_result,
	output logic flag_negative,
	output logic flag_zero,
	output logic flag_carry,
	output logic flag_overflow
);
	import alu32f_pkg::*;
	flags_t fl_q, nf;
	logic [DataW-1:0] r, a, b, x, y, fill;
	logic [DataW:0] sum;
	logic [7:0] s;
	logic [4:0] k;
	logic cin, go;
	logic [15:0] h;

	assign a = q_item.a;
	assign b = q_item.b;
	assign s = b[7:0];
	assign k = s[4:0];
	assign fill = {DataW{a[DataW-1]}};
	assign q_ready = !out_valid || out_ready;
	assign go = q_valid && q_ready;

	always_comb begin
		// shared adder operands
		x = a;
		y = b;
		cin = 1'b0;
		case (q_item.op)
			OP_ADCS: cin = fl_q.c;
			OP_CMP, OP_SUBS: begin y = ~b; cin = 1'b1; end
			OP_SBCS: begin y = ~b; cin = fl_q.c; end
			OP_RSBS: begin x = '0; y = ~a; cin = 1'b1; end
			default: ;
		endcase
	end
	assign sum = {1'b0, x} + {1'b0, y} + {{DataW{1'b0}}, cin};

	always_comb begin
		nf = fl_q;
		r = '0;
		h = {b[7:0], b[15:8]};
		case (q_item.op)
			OP_ADCS, OP_ADDS, OP_CMN, OP_CMP, OP_RSBS, OP_SBCS, OP_SUBS: begin
				r = sum[DataW-1:0];
				nf.c = sum[DataW];
				nf.v = ~(x[DataW-1] ^ y[DataW-1]) & (x[DataW-1] ^ r[DataW-1]);
			end
			OP_ADD: r = a + b;
			OP_SUB: r = a - b;
			OP_ANDS, OP_TST: r = a & b;
			OP_BICS: r = a & ~b;
			OP_EORS: r = a ^ b;
			OP_ORRS: r = a | b;
			OP_MOV, OP_MOVS: r = b;
			OP_MVNS: r = ~b;
			OP_MULS: r = a * b;
			OP_REV: r = {b[7:0], b[15:8], b[23:16], b[31:24]};
			OP_REV16: r = {b[23:16], b[31:24], b[7:0], b[15:8]};
			OP_REVSH: r = {{16{h[15]}}, h};
			OP_ASRS: begin
				if (s == 8'd0) r = a;
				else if (s < 8'd32) begin
					r = DataW'($signed(a) >>> k);
					nf.c = a[k - 5'd1];
				end else begin
					r = fill;
					nf.c = a[DataW-1];
				end
			end
			OP_LSLS: begin
				if (s == 8'd0) r = a;
				else if (s < 8'd32) begin
					r = a << k;
					nf.c = a[5'd0 - k];
				end else begin
					r = '0;
					nf.c = (s == 8'd32) && a[0];
				end
			end
			OP_LSRS: begin
				if (s == 8'd0) r = a;
				else if (s < 8'd32) begin
					r = a >> k;
					nf.c = a[k - 5'd1];
				end else begin
					r = '0;
					nf.c = (s == 8'd32) && a[DataW-1];
				end
			end
			OP_RORS: begin
				r = (a >> k) | (a << (6'd32 - {1'b0, k}));
				if (k == 5'd0) r = a;
				if (s != 8'd0) nf.c = r[DataW-1];
			end
			default: ;
		endcase
		case (q_item.op)
			OP_ADCS, OP_ADDS, OP_CMN, OP_CMP, OP_RSBS, OP_SBCS, OP_SUBS, OP_ANDS,
			OP_TST, OP_BICS, OP_EORS, OP_ORRS, OP_MOVS, OP_MVNS, OP_MULS, OP_ASRS,
			OP_LSLS, OP_LSRS, OP_RORS: begin
				nf.n = r[DataW-1];
				nf.z = (r == '0);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fl_q <= '0;
			out_valid <= 1'b0;
		end else begin
			if (go) begin
				fl_q <= nf;
				out_valid <= 1'b1;
			end else if (out_ready) out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			result <= q_item.wr ? r : '0;
			writes_result <= q_item.wr;
			flag_negative <= nf.n;
			flag_zero <= nf.z;
			flag_carry <= nf.c;
			flag_overflow <= nf.v;
		end
	end
endmodule

[bench/tb_top.sv]
// tb_top: randomized self-checking bench for the 32-bit alu with nzcv flags
// depends on alu32f_pkg, alu32f_if and alu32_with_condition_flags_unit
`timescale 1ns / 1ps
module tb_top;
	import alu32f_pkg::*;

	// word layouts carried by the two channels
	typedef struct packed {
		logic [OpW-1:0] opcode;
		logic [DataW-1:0] operand_a;
		logic [DataW-1:0] operand_b;
	} alu_op_t;

	typedef struct packed {
		logic [DataW-1:0] result;
		logic writes_result;
		logic flag_negative;
		logic flag_zero;
		logic flag_carry;
		logic flag_overflow;
	} alu_res_t;

	localparam int unsigned IdleLimit = 4000;
	localparam int unsigned RandomOps = 1900;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	alu32f_if #(.payload_t(alu_op_t)) in_ch ();
	alu32f_if #(.payload_t(alu_res_t)) out_ch ();

	alu32_with_condition_flags_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch.sink),
		.out_ch(out_ch.source)
	);

	always #6 clk = ~clk;

	// ops waiting to be offered, and results predicted for accepted ops
	alu_op_t pending_ops[$];
	alu_res_t expected_results[$];
	flags_t model_flags;
	int errors = 0;
	int results_seen = 0;
	int idle_cycles = 0;

	// add with carry in, updating all four model flags
	function automatic logic [31:0] add_with_flags(logic [31:0] x, logic [31:0] y,
		logic cin);
		logic [32:0] sum;
		begin
			sum = {1'b0, x} + {1'b0, y} + {32'd0, cin};
			model_flags.n = sum[31];
			model_flags.z = (sum[31:0] == 32'd0);
			model_flags.c = sum[32];
			model_flags.v = (x[31] == y[31]) && (sum[31] != x[31]);
			return sum[31:0];
		end
	endfunction

	function automatic void set_nz(logic [31:0] r);
		model_flags.n = r[31];
		model_flags.z = (r == 32'd0);
	endfunction

	// execute one op against the model flags and return the expected word
	function automatic alu_res_t alu_predict(alu_op_t op);
		alu_res_t res;
		logic [31:0] a, b, r;
		logic [7:0] amt;
		logic [4:0] rot;
		logic [15:0] half;
		logic wr;
		begin
			a = op.operand_a;
			b = op.operand_b;
			amt = b[7:0];
			r = 32'd0;
			wr = 1'b1;
			case (op.opcode)
				OP_ADCS: begin
					r = add_with_flags(a, b, model_flags.c);
				end
				OP_ADD: r = a + b;
				OP_ADDS: r = add_with_flags(a, b, 1'b0);
				OP_ANDS: begin r = a & b; set_nz(r); end
				OP_ASRS: begin
					if (amt == 0) begin
						r = a;
					end else if (amt < 32) begin
						r = $unsigned($signed(a) >>> amt);
						model_flags.c = a[amt - 1];
					end else begin
						r = {32{a[31]}};
						model_flags.c = a[31];
					end
					set_nz(r);
				end
				OP_BICS: begin r = a & ~b; set_nz(r); end
				OP_CMN: begin void'(add_with_flags(a, b, 1'b0)); wr = 1'b0; end
				OP_CMP: begin void'(add_with_flags(a, ~b, 1'b1)); wr = 1'b0; end
				OP_EORS: begin r = a ^ b; set_nz(r); end
				OP_LSLS: begin
					if (amt == 0) begin
						r = a;
					end else if (amt < 32) begin
						r = a << amt;
						model_flags.c = a[32 - amt];
					end else begin
						r = 32'd0;
						model_flags.c = (amt == 32) ? a[0] : 1'b0;
					end
					set_nz(r);
				end
				OP_LSRS: begin
					if (amt == 0) begin
						r = a;
					end else if (amt < 32) begin
						r = a >> amt;
						model_flags.c = a[amt - 1];
					end else begin
						r = 32'd0;
						model_flags.c = (amt == 32) ? a[31] : 1'b0;
					end
					set_nz(r);
				end
				OP_MOV: r = b;
				OP_MOVS: begin r = b; set_nz(r); end
				OP_MULS: begin r = a * b; set_nz(r); end
				OP_MVNS: begin r = ~b; set_nz(r); end
				OP_ORRS: begin r = a | b; set_nz(r); end
				OP_REV: r = {b[7:0], b[15:8], b[23:16], b[31:24]};
				OP_REV16: r = {b[23:16], b[31:24], b[7:0], b[15:8]};
				OP_REVSH: begin
					half = {b[7:0], b[15:8]};
					r = {{16{half[15]}}, half};
				end
				OP_RORS: begin
					rot = amt[4:0];
					if (amt == 0) begin
						r = a;
					end else if (rot == 0) begin
						r = a;
						model_flags.c = a[31];
					end else begin
						r = (a >> rot) | (a << (32 - rot));
						model_flags.c = r[31];
					end
					set_nz(r);
				end
				OP_RSBS: r = add_with_flags(32'd0, ~a, 1'b1);
				OP_SBCS: r = add_with_flags(a, ~b, model_flags.c);
				OP_SUB: r = a - b;
				OP_SUBS: r = add_with_flags(a, ~b, 1'b1);
				OP_TST: begin set_nz(a & b); wr = 1'b0; end
				default: wr = 1'b0; // nop and the unused codes
			endcase
			res.result = wr ? r : 32'd0;
			res.writes_result = wr;
			res.flag_negative = model_flags.n;
			res.flag_zero = model_flags.z;
			res.flag_carry = model_flags.c;
			res.flag_overflow = model_flags.v;
			return res;
		end
	endfunction

	// gaps: mostly none, some short, a few long
	function automatic int draw_gap();
		int pick;
		begin
			pick = $urandom_range(99);
			if (pick < 65) return 0;
			if (pick < 95) return $urandom_range(1, 3);
			return $urandom_range(10, 40);
		end
	endfunction

	// operand mix: corners often, random otherwise
	function automatic logic [31:0] pick_operand();
		case ($urandom_range(9))
			0: return 32'h0000_0000;
			1: return 32'hFFFF_FFFF;
			2: return 32'h8000_0000;
			3: return 32'h7FFF_FFFF;
			4: return 32'h0000_0001;
			default: return $urandom();
		endcase
	endfunction

	// shift amounts cluster on the boundaries, upper bits stay random
	function automatic logic [31:0] pick_shift();
		logic [31:0] v;
		begin
			v = $urandom();
			case ($urandom_range(9))
				0: v[7:0] = 8'd0;
				1: v[7:0] = 8'd1;
				2: v[7:0] = 8'd31;
				3: v[7:0] = 8'd32;
				4: v[7:0] = 8'd33;
				5: v[7:0] = 8'd64;
				6: v[7:0] = 8'hFF;
				7: v[7:0] = $urandom_range(0, 40);
				default: ;
			endcase
			return v;
		end
	endfunction

	function automatic alu_op_t make_op(logic [4:0] code, logic [31:0] a, logic [31:0] b);
		alu_op_t op;
		begin
			op.opcode = code;
			op.operand_a = a;
			op.operand_b = b;
			return op;
		end
	endfunction

	// sender: offers queued words, predicts each one as it is accepted
	int send_gap = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			in_ch.payload <= '0;
			model_flags = '0;
			send_gap = 0;
		end else begin
			if (in_ch.valid && in_ch.ready) begin
				expected_results.push_back(alu_predict(in_ch.payload));
				send_gap = draw_gap();
			end
			// slot free: either nothing offered or the offer just went through
			if (!in_ch.valid || in_ch.ready) begin
				if (send_gap > 0) begin
					send_gap--;
					in_ch.valid <= 1'b0;
				end else if (pending_ops.size() > 0) begin
					in_ch.valid <= 1'b1;
					in_ch.payload <= pending_ops.pop_front();
				end else begin
					in_ch.valid <= 1'b0;
				end
			end
		end
	end

	// receiver: random stalls, one long hold-off once the run is under way
	int hold_cycles = 0;
	bit long_hold_done = 1'b0;
	always @(posedge clk or negedge arst_n) begin
		alu_res_t got, want;
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				got = out_ch.payload;
				results_seen++;
				if (expected_results.size() == 0) begin
					errors++;
					$display("%0t: result word with nothing expected: %h", $time, got);
				end else begin
					want = expected_results.pop_front();
					if (got.result !== want.result) begin
						errors++;
						$display("%0t: result expected %h actual %h", $time,
							want.result, got.result);
					end
					if (got.writes_result !== want.writes_result) begin
						errors++;
						$display("%0t: writes_result expected %b actual %b", $time,
							want.writes_result, got.writes_result);
					end
					if (got.flag_negative !== want.flag_negative) begin
						errors++;
						$display("%0t: flag_negative expected %b actual %b", $time,
							want.flag_negative, got.flag_negative);
					end
					if (got.flag_zero !== want.flag_zero) begin
						errors++;
						$display("%0t: flag_zero expected %b actual %b", $time,
							want.flag_zero, got.flag_zero);
					end
					if (got.flag_carry !== want.flag_carry) begin
						errors++;
						$display("%0t: flag_carry expected %b actual %b", $time,
							want.flag_carry, got.flag_carry);
					end
					if (got.flag_overflow !== want.flag_overflow) begin
						errors++;
						$display("%0t: flag_overflow expected %b actual %b", $time,
							want.flag_overflow, got.flag_overflow);
					end
				end
			end
			// long hold-off lets the queue fill and back up the input
			if (!long_hold_done && results_seen == 400) begin
				long_hold_done = 1'b1;
				hold_cycles = 80;
			end else if (hold_cycles == 0) begin
				hold_cycles = draw_gap();
			end
			if (hold_cycles > 0) begin
				hold_cycles--;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

	// watchdog: counts cycles with no word moving on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
				if (idle_cycles >= IdleLimit) begin
					$display("FAILURE");
					$finish;
				end
			end
		end
	end

	// wait until every queued op is sent and every result is back
	task automatic wait_drained();
		while (pending_ops.size() > 0 || in_ch.valid || expected_results.size() > 0)
			@(posedge clk);
	endtask

	initial begin
		logic [4:0] code;
		logic [31:0] a, b;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// directed: corners of the arithmetic, shift boundaries, every opcode
		pending_ops.push_back(make_op(OP_ADDS, 32'h7FFF_FFFF, 32'h0000_0001));
		pending_ops.push_back(make_op(OP_ADDS, 32'hFFFF_FFFF, 32'h0000_0001));
		pending_ops.push_back(make_op(OP_ADCS, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
		pending_ops.push_back(make_op(OP_SUBS, 32'h0000_0000, 32'h0000_0001));
		pending_ops.push_back(make_op(OP_SBCS, 32'h8000_0000, 32'h0000_0001));
		pending_ops.push_back(make_op(OP_CMP, 32'h8000_0000, 32'h7FFF_FFFF));
		pending_ops.push_back(make_op(OP_CMN, 32'hFFFF_FFFF, 32'h0000_0001));
		pending_ops.push_back(make_op(OP_RSBS, 32'h8000_0000, 32'h0));
		pending_ops.push_back(make_op(OP_LSLS, 32'h0000_0001, 32'h0000_0020));
		pending_ops.push_back(make_op(OP_LSLS, 32'hFFFF_FFFF, 32'hFFFF_FF21));
		pending_ops.push_back(make_op(OP_LSRS, 32'h8000_0000, 32'h0000_0020));
		pending_ops.push_back(make_op(OP_ASRS, 32'h8000_0001, 32'h0000_0028));
		pending_ops.push_back(make_op(OP_ASRS, 32'h8000_0000, 32'h0000_1F00));
		pending_ops.push_back(make_op(OP_RORS, 32'h8000_0001, 32'h0000_0040));
		pending_ops.push_back(make_op(OP_RORS, 32'h0000_0010, 32'h0000_0004));
		pending_ops.push_back(make_op(OP_REVSH, 32'h0, 32'hFFFF_0080));
		pending_ops.push_back(make_op(OP_REV, 32'h0, 32'h1234_5678));
		pending_ops.push_back(make_op(OP_REV16, 32'h0, 32'h1234_5678));
		pending_ops.push_back(make_op(OP_MULS, 32'h0001_0000, 32'h0001_0000));
		pending_ops.push_back(make_op(OP_TST, 32'h8000_0000, 32'hFFFF_FFFF));
		pending_ops.push_back(make_op(OP_MOV, 32'h0, 32'h0));
		pending_ops.push_back(make_op(OP_MOVS, 32'h0, 32'h8000_0000));
		pending_ops.push_back(make_op(OP_MVNS, 32'h0, 32'hFFFF_FFFF));
		pending_ops.push_back(make_op(OP_ANDS, 32'hF0F0_F0F0, 32'h0F0F_0F0F));
		pending_ops.push_back(make_op(OP_BICS, 32'hFFFF_FFFF, 32'h0000_FFFF));
		pending_ops.push_back(make_op(OP_EORS, 32'hAAAA_AAAA, 32'h5555_5555));
		pending_ops.push_back(make_op(OP_ORRS, 32'h0, 32'h0));
		pending_ops.push_back(make_op(OP_ADD, 32'hFFFF_FFFF, 32'h2));
		pending_ops.push_back(make_op(OP_SUB, 32'h0, 32'h1));
		pending_ops.push_back(make_op(OP_NOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
		pending_ops.push_back(make_op(5'd31, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
		// sender pauses here until every result is back
		wait_drained();

		// random: mostly defined opcodes, some unused codes
		for (int i = 0; i < RandomOps; i++) begin
			code = ($urandom_range(19) == 0) ? 5'($urandom_range(26, 31))
				: 5'($urandom_range(0, 25));
			a = pick_operand();
			b = (code == OP_ASRS || code == OP_LSLS || code == OP_LSRS || code == OP_RORS)
				? pick_shift() : pick_operand();
			pending_ops.push_back(make_op(code, a, b));
		end
		wait_drained();
		repeat (10) @(posedge clk);

		if (errors == 0 && expected_results.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end
endmodule

[sim.f]
rtl/alu32f_pkg.sv
rtl/alu32f_if.sv
rtl/alu32f_front.sv
rtl/alu32f_back.sv
rtl/alu32_with_condition_flags_unit.sv
bench/tb_top.sv
